// ===== rtl/ttf_pkg.sv =====
package ttf_pkg;

    // Table geometry
    localparam int NUM_TRACKS = 16;
    localparam int IDX_W      = $clog2(NUM_TRACKS);
    localparam int CNT_W      = $clog2(NUM_TRACKS + 1);

    // Register reset values
    localparam logic [15:0] DEFAULT_SIGMA_RST = 16'd512;
    localparam logic [15:0] MAX_SIGMA_RST     = 16'd5120;
    localparam logic [15:0] MIN_MERGE_RST     = 16'd256;
    localparam logic [15:0] MAX_SPEED_RST     = 16'd66;

    localparam logic OP_AGE  = 1'b0;
    localparam logic OP_PEAK = 1'b1;

    typedef enum logic [1:0] {
        REG_DEFAULT_SIGMA = 2'd0,
        REG_MAX_SIGMA     = 2'd1,
        REG_MIN_MERGE     = 2'd2,
        REG_MAX_SPEED     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_AGED    = 2'd0,
        ACT_MERGED  = 2'd1,
        ACT_CREATED = 2'd2,
        ACT_IGNORED = 2'd3
    } action_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] timestamp;
        logic [7:0]  peak_x;
        logic [7:0]  peak_y;
        logic [15:0] peak_weight;
    } in_t;

    typedef struct packed {
        action_t     action;
        logic [4:0]  expired_count;
        logic [3:0]  created_slot;
        logic [3:0]  best_track;
        logic [15:0] best_x;
        logic [15:0] best_y;
        logic [31:0] best_weight;
        logic [3:0]  sharpest_track;
    } out_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] sigma;
        logic [31:0] weight;
        logic [31:0] stamp;
    } track_t;

    // Divider request: wide selects 32 quotient bits, else 16
    typedef struct packed {
        logic        start;
        logic        wide;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        start;
        logic [31:0] value;
    } sqrt_req_t;

endpackage

// ===== rtl/ttf_div.sv =====
module ttf_div import ttf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  div_req_t    req,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [31:0] quo_reg, quo_next;
    logic [33:0] trial;
    logic        ge;

    // One restoring step per cycle, quotient bound known in advance
    always_comb begin
        trial     = {rem_reg, dvd_reg[63]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            dvs_next  = req.divisor;
            quo_next  = '0;
            if (req.wide) begin
                rem_next = 33'(req.dividend >> 32);
                dvd_next = req.dividend << 32;
                cnt_next = 5'd31;
            end else begin
                rem_next = 33'(req.dividend >> 16);
                dvd_next = req.dividend << 48;
                cnt_next = 5'd15;
            end
        end else if (busy_reg) begin
            rem_next = ge ? 33'(trial - {1'b0, dvs_reg}) : trial[32:0];
            quo_next = {quo_reg[30:0], ge};
            dvd_next = dvd_reg << 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/ttf_sqrt.sv =====
module ttf_sqrt import ttf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sqrt_req_t   req,
    output logic        done,
    output logic [15:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] one_reg, one_next;
    logic [32:0] sum;

    // Digit-by-digit root, two radicand bits per cycle
    always_comb begin
        sum       = 33'(res_reg) + 33'(one_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        res_next  = res_reg;
        one_next  = one_reg;
        if (req.start) begin
            busy_next = 1'b1;
            val_next  = req.value;
            res_next  = '0;
            one_next  = 32'h4000_0000;
            cnt_next  = 4'd15;
        end else if (busy_reg) begin
            if ({1'b0, val_reg} >= sum) begin
                val_next = val_reg - sum[31:0];
                res_next = (res_reg >> 1) + one_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            one_next = one_reg >> 2;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        res_reg <= res_next;
        one_reg <= one_next;
    end

    assign done = done_reg;
    assign root = res_reg[15:0];

endmodule

// ===== rtl/track_table_fusion.sv =====
// Track table of 16 point tracks with inverse-variance fusion. One transaction is taken at a
// time: s_ready is high only while the block is idle, and the result stays on m_data until it
// is taken. Time per transaction is set by a sequencer that walks the slots one after another
// through one shared 32x32 multiplier, a 1-bit-per-cycle divider and a 2-bit-per-cycle root
// unit. An aging transaction visits every slot; an ignored peak goes straight to the result.
// A peak visits every slot, and each slot it is fused into adds up to two 16-step and two
// 32-step divides and one 16-step root. Configuration writes land at once and must only be
// issued while idle.
module track_table_fusion import ttf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_AGE_SCAN, ST_AGE_WB, ST_PK_VC, ST_PK_R2, ST_PK_START, ST_PK_SCAN,
        ST_PK_DY, ST_PK_S2, ST_PK_CMP, ST_FU_XP, ST_FU_YT, ST_FU_YP, ST_FU_VV, ST_FU_WT,
        ST_FU_DX, ST_DIV_GO, ST_DIV_WAIT, ST_FU_SQW, ST_FU_DW, ST_FU_DWW, ST_FU_WB,
        ST_PK_BEST, ST_PK_END, ST_OUT_RD, ST_OUT_V
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [15:0] dsig_reg, msig_reg, mdist_reg, speed_reg;

    // Track table
    logic [15:0] tx_reg   [NUM_TRACKS];
    logic [15:0] ty_reg   [NUM_TRACKS];
    logic [15:0] tsig_reg [NUM_TRACKS];
    logic [31:0] tw_reg   [NUM_TRACKS];
    logic [31:0] tt_reg   [NUM_TRACKS];

    // Sequencer state
    logic [IDX_W-1:0] idx_reg, idx_next;
    in_t              item_reg, item_next;
    action_t          act_reg, act_next;
    logic [CNT_W-1:0] exp_reg, exp_next;
    logic [IDX_W-1:0] created_reg, created_next;
    logic [IDX_W-1:0] hi_reg, hi_next, si_reg, si_next;
    logic [IDX_W-1:0] hc_reg, hc_next, sc_reg, sc_next;
    logic [31:0]      hw_reg, hw_next;
    logic [15:0]      ss_reg, ss_next;
    logic             seen_reg, seen_next, merged_reg, merged_next;
    logic [IDX_W-1:0] old_reg, old_next;
    logic [31:0]      otime_reg, otime_next;
    logic [63:0]      prod_reg, prod_next;
    logic [31:0]      vc_reg, vc_next, r2_reg, r2_next, vp_reg, vp_next;
    logic [32:0]      d2_reg, d2_next;
    logic [63:0]      numx_reg, numx_next, numy_reg, numy_next, numv_reg, numv_next;
    logic [47:0]      numw_reg, numw_next;
    logic [1:0]       fstep_reg, fstep_next;
    logic [15:0]      nx_reg, nx_next, ny_reg, ny_next, ns_reg, ns_next;
    logic [31:0]      wq_reg, wq_next;
    out_t             out_reg, out_next;

    // Datapath signals
    logic [IDX_W-1:0] rd_idx;
    track_t           cur;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    track_t           wr_entry;
    logic [31:0]      mul_a, mul_b;
    logic [15:0]      cx, cy, dx_abs, dy_abs, mid_x, mid_y, age_sig;
    logic [31:0]      dt;
    logic [32:0]      den;
    logic [40:0]      age_sum;
    logic [32:0]      w_sum;
    logic             wsat, last;
    div_req_t         div_req;
    sqrt_req_t        sq_req;
    logic             div_done, sq_done;
    logic [31:0]      div_quo;
    logic [15:0]      sq_root;

    ttf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    ttf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Single read port into the table
    always_comb begin
        rd_idx     = (state_reg == ST_OUT_RD) ? hi_reg : idx_reg;
        cur.x      = tx_reg[rd_idx];
        cur.y      = ty_reg[rd_idx];
        cur.sigma  = tsig_reg[rd_idx];
        cur.weight = tw_reg[rd_idx];
        cur.stamp  = tt_reg[rd_idx];
    end

    // Per-slot arithmetic around the shared units
    always_comb begin
        cx      = {item_reg.peak_x, 8'h00};
        cy      = {item_reg.peak_y, 8'h00};
        dx_abs  = (cur.x >= cx) ? cur.x - cx : cx - cur.x;
        dy_abs  = (cur.y >= cy) ? cur.y - cy : cy - cur.y;
        dt      = (item_reg.timestamp > cur.stamp) ? item_reg.timestamp - cur.stamp : '0;
        den     = 33'(vp_reg) + 33'(vc_reg);
        mid_x   = 16'((17'(cur.x) + 17'(cx) + 17'd1) >> 1);
        mid_y   = 16'((17'(cur.y) + 17'(cy) + 17'd1) >> 1);
        age_sum = 41'(cur.sigma) + 41'(prod_reg[47:8]);
        age_sig = (|age_sum[40:16]) ? 16'hFFFF : age_sum[15:0];
        w_sum   = 33'(wq_reg) + 33'({item_reg.peak_weight, 8'h00});
        wsat    = (cur.sigma == '0) || (numw_reg[47:32] >= cur.sigma);
        last    = (idx_reg == IDX_W'(NUM_TRACKS - 1));
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_AGE_SCAN: begin mul_a = 32'(speed_reg);     mul_b = dt;               end
            ST_PK_VC:    begin mul_a = 32'(dsig_reg);      mul_b = 32'(dsig_reg);    end
            ST_PK_R2:    begin mul_a = 32'(mdist_reg);     mul_b = 32'(mdist_reg);   end
            ST_PK_SCAN:  begin mul_a = 32'(dx_abs);        mul_b = 32'(dx_abs);      end
            ST_PK_DY:    begin mul_a = 32'(dy_abs);        mul_b = 32'(dy_abs);      end
            ST_PK_S2:    begin mul_a = 32'(cur.sigma);     mul_b = 32'(cur.sigma);   end
            ST_PK_CMP:   begin mul_a = 32'(cur.x);         mul_b = vc_reg;           end
            ST_FU_XP:    begin mul_a = 32'(item_reg.peak_x); mul_b = vp_reg;         end
            ST_FU_YT:    begin mul_a = 32'(cur.y);         mul_b = vc_reg;           end
            ST_FU_YP:    begin mul_a = 32'(item_reg.peak_y); mul_b = vp_reg;         end
            ST_FU_VV:    begin mul_a = vp_reg;             mul_b = vc_reg;           end
            ST_FU_WT:    begin mul_a = cur.weight;         mul_b = 32'(dsig_reg);    end
            default:     begin mul_a = '0;                 mul_b = '0;               end
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // Requests to the divider and root unit
    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO) || (state_reg == ST_FU_DW && !wsat);
        div_req.wide  = (state_reg == ST_FU_DW) || (fstep_reg == 2'd2);
        if (state_reg == ST_FU_DW) begin
            div_req.dividend = 64'(numw_reg);
            div_req.divisor  = 33'(cur.sigma);
        end else begin
            div_req.divisor = den;
            case (fstep_reg)
                2'd0:    div_req.dividend = numx_reg;
                2'd1:    div_req.dividend = numy_reg;
                default: div_req.dividend = numv_reg;
            endcase
        end
        sq_req.start = (state_reg == ST_DIV_WAIT) && div_done && (fstep_reg == 2'd2);
        sq_req.value = div_quo;
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        item_next    = item_reg;
        act_next     = act_reg;
        exp_next     = exp_reg;
        created_next = created_reg;
        hi_next      = hi_reg;
        si_next      = si_reg;
        hc_next      = hc_reg;
        sc_next      = sc_reg;
        hw_next      = hw_reg;
        ss_next      = ss_reg;
        seen_next    = seen_reg;
        merged_next  = merged_reg;
        old_next     = old_reg;
        otime_next   = otime_reg;
        vc_next      = vc_reg;
        r2_next      = r2_reg;
        vp_next      = vp_reg;
        d2_next      = d2_reg;
        numx_next    = numx_reg;
        numy_next    = numy_reg;
        numv_next    = numv_reg;
        numw_next    = numw_reg;
        fstep_next   = fstep_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        ns_next      = ns_reg;
        wq_next      = wq_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_idx       = idx_reg;
        wr_entry     = cur;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    idx_next     = '0;
                    exp_next     = '0;
                    created_next = '0;
                    seen_next    = 1'b0;
                    merged_next  = 1'b0;
                    hc_next      = '0;
                    sc_next      = '0;
                    if (s_data.operation == OP_AGE) begin
                        act_next   = ACT_AGED;
                        state_next = ST_AGE_SCAN;
                    end else if (s_data.peak_weight == '0) begin
                        act_next   = ACT_IGNORED;
                        state_next = ST_OUT_RD;
                    end else begin
                        state_next = ST_PK_VC;
                    end
                end
            end

            // Aging: skip empty slots, grow sigma of active ones, clear those past max sigma or at time zero
            ST_AGE_SCAN: begin
                if (cur.stamp == '0) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = last ? ST_OUT_RD : ST_AGE_SCAN;
                end else begin
                    state_next = ST_AGE_WB;
                end
            end
            ST_AGE_WB: begin
                wr_en = 1'b1;
                if (age_sig > msig_reg || item_reg.timestamp == '0) begin
                    wr_entry = '0;
                    exp_next = exp_reg + 1'b1;
                end else begin
                    wr_entry.sigma = age_sig;
                    wr_entry.stamp = item_reg.timestamp;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = last ? ST_OUT_RD : ST_AGE_SCAN;
            end

            // Peak: square the two constants first
            ST_PK_VC:    state_next = ST_PK_R2;
            ST_PK_R2: begin
                vc_next    = prod_reg[31:0];
                state_next = ST_PK_START;
            end
            ST_PK_START: begin
                r2_next    = prod_reg[31:0];
                state_next = ST_PK_SCAN;
            end
            ST_PK_SCAN: begin
                if (idx_reg == '0) begin
                    old_next   = '0;
                    otime_next = cur.stamp;
                end else if (cur.stamp < otime_reg) begin
                    old_next   = idx_reg;
                    otime_next = cur.stamp;
                end
                if (cur.stamp == '0) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = last ? ST_PK_END : ST_PK_SCAN;
                end else begin
                    state_next = ST_PK_DY;
                end
            end
            ST_PK_DY: begin
                d2_next    = 33'(prod_reg[31:0]);
                state_next = ST_PK_S2;
            end
            ST_PK_S2: begin
                d2_next    = d2_reg + 33'(prod_reg[31:0]);
                state_next = ST_PK_CMP;
            end
            ST_PK_CMP: begin
                vp_next = prod_reg[31:0];
                if (d2_reg < 33'(prod_reg[31:0]) || d2_reg < 33'(r2_reg)) begin
                    merged_next = 1'b1;
                    state_next  = ST_FU_XP;
                end else begin
                    state_next = ST_PK_BEST;
                end
            end

            // Fusion numerators
            ST_FU_XP: begin
                numx_next  = prod_reg + 64'(den >> 1);
                state_next = ST_FU_YT;
            end
            ST_FU_YT: begin
                numx_next  = numx_reg + (prod_reg << 8);
                state_next = ST_FU_YP;
            end
            ST_FU_YP: begin
                numy_next  = prod_reg + 64'(den >> 1);
                state_next = ST_FU_VV;
            end
            ST_FU_VV: begin
                numy_next  = numy_reg + (prod_reg << 8);
                state_next = ST_FU_WT;
            end
            ST_FU_WT: begin
                numv_next  = prod_reg;
                state_next = ST_FU_DX;
            end
            ST_FU_DX: begin
                numw_next = prod_reg[47:0];
                if (den == '0) begin
                    nx_next    = mid_x;
                    ny_next    = mid_y;
                    ns_next    = '0;
                    state_next = ST_FU_DW;
                end else begin
                    fstep_next = 2'd0;
                    state_next = ST_DIV_GO;
                end
            end

            // Position, variance quotient, then root
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (fstep_reg)
                        2'd0: begin
                            nx_next    = div_quo[15:0];
                            fstep_next = 2'd1;
                            state_next = ST_DIV_GO;
                        end
                        2'd1: begin
                            ny_next    = div_quo[15:0];
                            fstep_next = 2'd2;
                            state_next = ST_DIV_GO;
                        end
                        default: state_next = ST_FU_SQW;
                    endcase
                end
            end
            ST_FU_SQW: begin
                if (sq_done) begin
                    ns_next    = sq_root;
                    state_next = ST_FU_DW;
                end
            end

            // Weight scaling, saturate when the quotient cannot fit
            ST_FU_DW: begin
                if (wsat) begin
                    wq_next    = '1;
                    state_next = ST_FU_WB;
                end else begin
                    state_next = ST_FU_DWW;
                end
            end
            ST_FU_DWW: begin
                if (div_done) begin
                    wq_next    = div_quo;
                    state_next = ST_FU_WB;
                end
            end
            ST_FU_WB: begin
                wr_en           = 1'b1;
                wr_entry.x      = nx_reg;
                wr_entry.y      = ny_reg;
                wr_entry.sigma  = ns_reg;
                wr_entry.weight = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                wr_entry.stamp  = item_reg.timestamp;
                if (old_reg == idx_reg) begin
                    otime_next = item_reg.timestamp;
                end
                state_next = ST_PK_BEST;
            end

            // Running best over active slots, after fusion
            ST_PK_BEST: begin
                if (!seen_reg || cur.weight > hw_reg) begin
                    hc_next = idx_reg;
                    hw_next = cur.weight;
                end
                if (!seen_reg || cur.sigma < ss_reg) begin
                    sc_next = idx_reg;
                    ss_next = cur.sigma;
                end
                seen_next  = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = last ? ST_PK_END : ST_PK_SCAN;
            end
            ST_PK_END: begin
                hi_next = hc_reg;
                si_next = sc_reg;
                if (merged_reg) begin
                    act_next = ACT_MERGED;
                end else begin
                    act_next        = ACT_CREATED;
                    created_next    = old_reg;
                    wr_en           = 1'b1;
                    wr_idx          = old_reg;
                    wr_entry.x      = cx;
                    wr_entry.y      = cy;
                    wr_entry.sigma  = dsig_reg;
                    wr_entry.weight = {8'h00, item_reg.peak_weight, 8'h00};
                    wr_entry.stamp  = item_reg.timestamp;
                end
                state_next = ST_OUT_RD;
            end

            // Build the result from the heaviest slot
            ST_OUT_RD: begin
                out_next.action         = act_reg;
                out_next.expired_count  = 5'(exp_reg);
                out_next.created_slot   = 4'(created_reg);
                out_next.best_track     = 4'(hi_reg);
                out_next.best_x         = cur.x;
                out_next.best_y         = cur.y;
                out_next.best_weight    = cur.weight;
                out_next.sharpest_track = 4'(si_reg);
                state_next              = ST_OUT_V;
            end
            ST_OUT_V: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hi_reg    <= '0;
            si_reg    <= '0;
            dsig_reg  <= DEFAULT_SIGMA_RST;
            msig_reg  <= MAX_SIGMA_RST;
            mdist_reg <= MIN_MERGE_RST;
            speed_reg <= MAX_SPEED_RST;
            for (int i = 0; i < NUM_TRACKS; i++) begin
                tx_reg[i]   <= '0;
                ty_reg[i]   <= '0;
                tsig_reg[i] <= '0;
                tw_reg[i]   <= '0;
                tt_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            hi_reg    <= hi_next;
            si_reg    <= si_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEFAULT_SIGMA: dsig_reg  <= cfg_data;
                    REG_MAX_SIGMA:     msig_reg  <= cfg_data;
                    REG_MIN_MERGE:     mdist_reg <= cfg_data;
                    REG_MAX_SPEED:     speed_reg <= cfg_data;
                    default:           dsig_reg  <= dsig_reg;
                endcase
            end
            if (wr_en) begin
                tx_reg[wr_idx]   <= wr_entry.x;
                ty_reg[wr_idx]   <= wr_entry.y;
                tsig_reg[wr_idx] <= wr_entry.sigma;
                tw_reg[wr_idx]   <= wr_entry.weight;
                tt_reg[wr_idx]   <= wr_entry.stamp;
            end
        end
        idx_reg     <= idx_next;
        item_reg    <= item_next;
        act_reg     <= act_next;
        exp_reg     <= exp_next;
        created_reg <= created_next;
        hc_reg      <= hc_next;
        sc_reg      <= sc_next;
        hw_reg      <= hw_next;
        ss_reg      <= ss_next;
        seen_reg    <= seen_next;
        merged_reg  <= merged_next;
        old_reg     <= old_next;
        otime_reg   <= otime_next;
        prod_reg    <= prod_next;
        vc_reg      <= vc_next;
        r2_reg      <= r2_next;
        vp_reg      <= vp_next;
        d2_reg      <= d2_next;
        numx_reg    <= numx_next;
        numy_reg    <= numy_next;
        numv_reg    <= numv_next;
        numw_reg    <= numw_next;
        fstep_reg   <= fstep_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        ns_reg      <= ns_next;
        wq_reg      <= wq_next;
        out_reg     <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT_V);
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block ready again right after a transaction");

    a_expired_only_aging: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != ACT_AGED |-> m_data.expired_count == '0)
        else $error("expired count on a non-aging result");

    a_root_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_req.start |-> div_done)
        else $error("root started without a finished variance quotient");
`endif

endmodule
